@@ sv/cau_pkg.sv @@
// Package for the complex arithmetic unit: operation codes, stream field widths
// and status bit positions. Used by the top level and by its checker.
package cau_pkg;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	localparam int FIELD_W  = 32;
	localparam int OP_W     = 2;
	localparam int IN_W     = 4 * FIELD_W;
	localparam int OUT_W    = 2 * FIELD_W;
	localparam int FLAG_W   = 2;
	localparam int DZ_BIT   = 0;
	localparam int SAT_BIT  = 1;

endpackage

@@ sv/complex_arithmetic_unit.sv @@
// Complex arithmetic unit: pipelined add, subtract, multiply and divide on Q-format
// complex operands. Depends on cau_pkg for the operation codes and field layout.
//
// The unit takes one transaction per clock while the output is not stalled:
// four stages form the operand products, sums and magnitudes, one stage
// sets up the division, DATA_WIDTH stages each produce one quotient bit with a
// full-width compare and subtract, and a last stage saturates into the output register.
// All stages advance together; a stalled result holds the whole pipeline, and s_tready
// stays high while the output register is empty or being taken. Operands use the low
// DATA_WIDTH bits of each field, with FRAC_BITS fraction bits; results are sign-extended
// to 32 bits. Multiply and divide truncate toward zero, a zero divisor gives zero parts
// with div_zero set, and any clamped part sets saturated.
module complex_arithmetic_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// a_re, a_im, b_re, b_im
	input  logic [cau_pkg::IN_W-1:0]     s_tdata,
	// op
	input  logic [cau_pkg::OP_W-1:0]     s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// res_re, res_im
	output logic [cau_pkg::OUT_W-1:0]    m_tdata,
	// div_zero, saturated
	output logic [cau_pkg::FLAG_W-1:0]   m_tuser
);

	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int FW = cau_pkg::FIELD_W;
	localparam int PW = 2 * W;
	localparam int SW = 2 * W + 1;
	localparam int XW = 3 * W + F + 2;
	localparam int NS = W + 1;
	localparam int L  = NS + 5;

	logic [L-1:0] vld_s;
	logic         en;

	assign en       = !vld_s[L-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[L-2:0], s_tvalid};
		end
	end

	// stage 1: operand capture
	cau_pkg::op_t            op_s1;
	logic signed [W-1:0]     a_s1, b_s1, c_s1, d_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= cau_pkg::op_t'(s_tuser);
			a_s1  <= s_tdata[W-1:0];
			b_s1  <= s_tdata[FW+W-1:FW];
			c_s1  <= s_tdata[2*FW+W-1:2*FW];
			d_s1  <= s_tdata[3*FW+W-1:3*FW];
		end
	end

	// stage 2: products and part sums
	cau_pkg::op_t            op_s2;
	logic signed [PW-1:0]    ac_s2, bd_s2, ad_s2, bc_s2, cc_s2, dd_s2;
	logic signed [W:0]       sre_s2, sim_s2;
	logic                    cz_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2 <= op_s1;
			ac_s2 <= a_s1 * c_s1;
			bd_s2 <= b_s1 * d_s1;
			ad_s2 <= a_s1 * d_s1;
			bc_s2 <= b_s1 * c_s1;
			cc_s2 <= c_s1 * c_s1;
			dd_s2 <= d_s1 * d_s1;
			cz_s2 <= (c_s1 == '0) && (d_s1 == '0);
			if (op_s1 == cau_pkg::OP_SUB) begin
				sre_s2 <= $signed({a_s1[W-1], a_s1}) - $signed({c_s1[W-1], c_s1});
				sim_s2 <= $signed({b_s1[W-1], b_s1}) - $signed({d_s1[W-1], d_s1});
			end else begin
				sre_s2 <= $signed({a_s1[W-1], a_s1}) + $signed({c_s1[W-1], c_s1});
				sim_s2 <= $signed({b_s1[W-1], b_s1}) + $signed({d_s1[W-1], d_s1});
			end
		end
	end

	// stage 3: combine products, or pass the part sums for add and subtract
	cau_pkg::op_t            op_s3;
	logic signed [SW-1:0]    re_s3, im_s3;
	logic [PW-1:0]           den_s3;
	logic                    dz_s3;
	logic signed [SW-1:0]    ac_x, bd_x, ad_x, bc_x, re_n, im_n;

	always_comb begin
		ac_x = SW'(ac_s2);
		bd_x = SW'(bd_s2);
		ad_x = SW'(ad_s2);
		bc_x = SW'(bc_s2);
		case (op_s2)
			cau_pkg::OP_MUL: begin
				re_n = ac_x - bd_x;
				im_n = ad_x + bc_x;
			end
			cau_pkg::OP_DIV: begin
				re_n = ac_x + bd_x;
				im_n = bc_x - ad_x;
			end
			default: begin
				re_n = SW'(sre_s2);
				im_n = SW'(sim_s2);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3  <= op_s2;
			re_s3  <= re_n;
			im_s3  <= im_n;
			den_s3 <= PW'(cc_s2) + PW'(dd_s2);
			dz_s3  <= cz_s2 && (op_s2 == cau_pkg::OP_DIV);
		end
	end

	// stage 4: sign and magnitude
	cau_pkg::op_t            op_s4;
	logic [PW-1:0]           den_s4;
	logic                    dz_s4;
	logic                    neg_s4 [2];
	logic [SW-1:0]           mag_s4 [2];

	always_ff @(posedge clk) begin
		if (en) begin
			op_s4     <= op_s3;
			den_s4    <= den_s3;
			dz_s4     <= dz_s3;
			neg_s4[0] <= re_s3[SW-1];
			neg_s4[1] <= im_s3[SW-1];
			mag_s4[0] <= re_s3[SW-1] ? SW'(-re_s3) : SW'(re_s3);
			mag_s4[1] <= im_s3[SW-1] ? SW'(-im_s3) : SW'(im_s3);
		end
	end

	// division stages: index 0 sets up, index j yields quotient bit W-j
	logic [PW-1:0]           den_sd [NS];
	logic                    div_sd [NS];
	logic                    dz_sd  [NS];
	logic [XW-1:0]           rem_sd [2][NS];
	logic [W-1:0]            quo_sd [2][NS];
	logic                    ovf_sd [2][NS];
	logic                    neg_sd [2][NS];
	logic [SW-1:0]           val_sd [2][NS];

	always_ff @(posedge clk) begin
		if (en) begin
			den_sd[0] <= den_s4;
			div_sd[0] <= (op_s4 == cau_pkg::OP_DIV);
			dz_sd[0]  <= dz_s4;
		end
	end

	for (genvar j = 1; j < NS; j++) begin : g_com
		always_ff @(posedge clk) begin
			if (en) begin
				den_sd[j] <= den_sd[j-1];
				div_sd[j] <= div_sd[j-1];
				dz_sd[j]  <= dz_sd[j-1];
			end
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [XW-1:0] num;

		assign num = XW'(mag_s4[l]) << F;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[l][0] <= num;
				quo_sd[l][0] <= '0;
				ovf_sd[l][0] <= num >= (XW'(den_s4) << W);
				neg_sd[l][0] <= neg_s4[l];
				val_sd[l][0] <= (op_s4 == cau_pkg::OP_MUL) ? (mag_s4[l] >> F) : mag_s4[l];
			end
		end

		for (genvar j = 1; j < NS; j++) begin : g_step
			localparam int K = W - j;
			logic [XW:0] dif;

			assign dif = {1'b0, rem_sd[l][j-1]} - ((XW+1)'(den_sd[j-1]) << K);

			always_ff @(posedge clk) begin
				if (en) begin
					rem_sd[l][j] <= dif[XW] ? rem_sd[l][j-1] : dif[XW-1:0];
					quo_sd[l][j] <= quo_sd[l][j-1] | (dif[XW] ? W'(0) : (W'(1) << K));
					ovf_sd[l][j] <= ovf_sd[l][j-1];
					neg_sd[l][j] <= neg_sd[l][j-1];
					val_sd[l][j] <= val_sd[l][j-1];
				end
			end
		end
	end

	// output stage: clamp and widen
	logic [FW-1:0]           res_so [2];
	logic                    sat_so [2];
	logic                    dz_so;

	for (genvar l = 0; l < 2; l++) begin : g_out
		logic [SW-1:0]       mg;
		logic signed [W-1:0] r;
		logic                sat;

		always_comb begin
			if (div_sd[W]) begin
				mg = ovf_sd[l][W] ? (SW'(1) << W) : SW'(quo_sd[l][W]);
			end else begin
				mg = val_sd[l][W];
			end
			sat = 1'b0;
			if (dz_sd[W]) begin
				r = '0;
			end else if (neg_sd[l][W]) begin
				if (mg > (SW'(1) << (W - 1))) begin
					r   = {1'b1, {(W-1){1'b0}}};
					sat = 1'b1;
				end else begin
					r = W'(-mg);
				end
			end else begin
				if (mg > ((SW'(1) << (W - 1)) - SW'(1))) begin
					r   = {1'b0, {(W-1){1'b1}}};
					sat = 1'b1;
				end else begin
					r = mg[W-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				res_so[l] <= FW'(r);
				sat_so[l] <= sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dz_so <= dz_sd[W];
		end
	end

	assign m_tdata = {res_so[1], res_so[0]};
	assign m_tuser = {sat_so[0] || sat_so[1], dz_so};

endmodule

@@ sv/cau_checker.sv @@
// Port-level checker for the complex arithmetic unit, bound to the top level.
// Depends on cau_pkg for the field layout and status bit positions.
module cau_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [cau_pkg::OUT_W-1:0]    m_tdata,
	input logic [cau_pkg::FLAG_W-1:0]   m_tuser
);

	localparam int FW = cau_pkg::FIELD_W;
	localparam logic [FW-1:0] MAXV = FW'((64'(1) << (DATA_WIDTH - 1)) - 64'(1));
	localparam logic [FW-1:0] MINV = ~MAXV;

	logic [FW-1:0] re, im;

	assign re = m_tdata[FW-1:0];
	assign im = m_tdata[2*FW-1:FW];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[cau_pkg::DZ_BIT] |->
			m_tdata == '0 && !m_tuser[cau_pkg::SAT_BIT])
		else $error("zero divisor result not cleared");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[cau_pkg::SAT_BIT] |->
			re == MAXV || re == MINV || im == MAXV || im == MINV)
		else $error("saturated flag without a bound value");

	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind complex_arithmetic_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (.*);
